### hw/rtl/mecanum_joystick_wheel_mixer_unit_defines.svh
// Assertion macros shared by the mecanum wheel mixer RTL.
`ifndef MECANUM_JOYSTICK_WHEEL_MIXER_UNIT_DEFINES_SVH
`define MECANUM_JOYSTICK_WHEEL_MIXER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MJWM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mixer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MJWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mixer assertion failed");

`endif

### hw/rtl/mjwm_pkg.sv
// Shared types, constants and register codes of the mecanum wheel mixer.
`timescale 1ns / 1ps
`default_nettype none
package mjwm_pkg;

  localparam int WHEEL_COUNT = 4;
  localparam int STICK_W     = 8;
  localparam int DUTY_W      = 8;
  localparam int GAIN_W      = 16;
  localparam int SPEED_W     = 10;   // signed wheel mix, -256..255
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int OUT_DATA_W  = 40;

  // Wheel order in every vector
  localparam int WHEEL_LF = 0;
  localparam int WHEEL_LR = 1;
  localparam int WHEEL_RF = 2;
  localparam int WHEEL_RR = 3;

  localparam logic KIND_TRANSLATE = 1'b0;
  localparam logic KIND_ROTATE    = 1'b1;

  localparam logic [GAIN_W-1:0] DEADZONE_RST = 16'd900;
  localparam logic [GAIN_W-1:0] TGAIN_RST    = 16'd47592;
  localparam logic [GAIN_W-1:0] RGAIN_RST    = 16'd39322;

  typedef enum logic [1:0] {
    REG_DEADZONE = 2'd0,
    REG_TGAIN    = 2'd1,
    REG_RGAIN    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] deadzone_sq;
    logic [GAIN_W-1:0] translate_gain;
    logic [GAIN_W-1:0] rotate_gain;
  } cfg_t;

  typedef struct packed {
    logic [WHEEL_COUNT-1:0][DUTY_W-1:0] duty;
    logic [WHEEL_COUNT-1:0]             dir;
  } mix_res_t;

endpackage
`default_nettype wire

### hw/rtl/mjwm_cfg_regs.sv
// Configuration register file with an APB-style write and read port.
`timescale 1ns / 1ps
`default_nettype none
module mjwm_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [mjwm_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [mjwm_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [mjwm_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                                  cfg_pready,
  output mjwm_pkg::cfg_t                        cfg
);
  import mjwm_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_DEADZONE: cfg_nxt.deadzone_sq    = cfg_pwdata[GAIN_W-1:0];
        REG_TGAIN:    cfg_nxt.translate_gain = cfg_pwdata[GAIN_W-1:0];
        REG_RGAIN:    cfg_nxt.rotate_gain    = cfg_pwdata[GAIN_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DEADZONE: cfg_prdata = CFG_DATA_W'(cfg_r.deadzone_sq);
      REG_TGAIN:    cfg_prdata = CFG_DATA_W'(cfg_r.translate_gain);
      REG_RGAIN:    cfg_prdata = CFG_DATA_W'(cfg_r.rotate_gain);
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadzone_sq    <= DEADZONE_RST;
      cfg_r.translate_gain <= TGAIN_RST;
      cfg_r.rotate_gain    <= RGAIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

### hw/rtl/mjwm_wheel.sv
// One wheel: scale a signed mix by a Q0.16 gain and resolve its direction bit.
`timescale 1ns / 1ps
`default_nettype none
module mjwm_wheel (
  input  wire logic signed [mjwm_pkg::SPEED_W-1:0] speed,
  input  wire logic        [mjwm_pkg::GAIN_W-1:0]  gain,
  input  wire logic                                en,
  input  wire logic                                dir_q,
  output logic             [mjwm_pkg::DUTY_W-1:0]  duty,
  output logic                                     dir_d
);
  import mjwm_pkg::*;

  localparam int MAG_W  = SPEED_W - 1;
  localparam int PROD_W = MAG_W + GAIN_W;

  logic                      neg;
  logic signed [SPEED_W-1:0] speed_n;
  logic        [MAG_W-1:0]   mag;
  logic        [PROD_W-1:0]  prod;

  assign neg     = speed[SPEED_W-1];
  assign speed_n = -speed;
  assign mag     = neg ? speed_n[MAG_W-1:0] : speed[MAG_W-1:0];
  assign prod    = PROD_W'(mag) * PROD_W'(gain);

  // Magnitude never passes 256, so the Q0.16 product fits the duty width
  assign duty  = en ? prod[GAIN_W +: DUTY_W] : '0;
  assign dir_d = (duty != '0) ? ~neg : dir_q;

endmodule
`default_nettype wire

### hw/rtl/mjwm_mixer.sv
// Centering, dead-zone test and mecanum mixing for one joystick sample.
`timescale 1ns / 1ps
`default_nettype none
module mjwm_mixer (
  input  wire logic                                  kind,
  input  wire logic [mjwm_pkg::STICK_W-1:0]          stick_x,
  input  wire logic [mjwm_pkg::STICK_W-1:0]          stick_y,
  input  wire mjwm_pkg::cfg_t                        cfg,
  input  wire logic [mjwm_pkg::WHEEL_COUNT-1:0]      dir_q,
  output mjwm_pkg::mix_res_t                         res
);
  import mjwm_pkg::*;

  localparam int SQ_W  = 2 * STICK_W;
  localparam int RAD_W = SQ_W + 1;
  localparam logic signed [SPEED_W-1:0] CENTER = SPEED_W'(127);

  logic signed [SPEED_W-1:0] x_s, y_s, x_n, y_n;
  logic        [STICK_W-1:0] x_abs, y_abs;
  logic        [SQ_W-1:0]    x_sq, y_sq;
  logic        [RAD_W-1:0]   radius;
  logic                      active;
  logic        [GAIN_W-1:0]  gain;
  logic signed [SPEED_W-1:0] speed [WHEEL_COUNT];

  assign x_s = $signed({2'b00, stick_x}) - CENTER;
  assign y_s = CENTER - $signed({2'b00, stick_y});
  assign x_n = -x_s;
  assign y_n = -y_s;

  // Magnitudes reach 128 at most, which still fits the stick width
  assign x_abs = x_s[SPEED_W-1] ? x_n[STICK_W-1:0] : x_s[STICK_W-1:0];
  assign y_abs = y_s[SPEED_W-1] ? y_n[STICK_W-1:0] : y_s[STICK_W-1:0];
  assign x_sq  = SQ_W'(x_abs) * SQ_W'(x_abs);
  assign y_sq  = SQ_W'(y_abs) * SQ_W'(y_abs);

  always_comb begin
    if (kind == KIND_ROTATE) begin
      radius            = RAD_W'(x_sq);
      gain              = cfg.rotate_gain;
      speed[WHEEL_LF]   = x_s;
      speed[WHEEL_LR]   = x_s;
      speed[WHEEL_RF]   = x_n;
      speed[WHEEL_RR]   = x_n;
    end else begin
      radius            = RAD_W'(x_sq) + RAD_W'(y_sq);
      gain              = cfg.translate_gain;
      speed[WHEEL_LF]   = x_s + y_s;
      speed[WHEEL_LR]   = y_s - x_s;
      speed[WHEEL_RF]   = y_s - x_s;
      speed[WHEEL_RR]   = x_s + y_s;
    end
  end

  assign active = radius >= RAD_W'(cfg.deadzone_sq);

  for (genvar w = 0; w < WHEEL_COUNT; w++) begin : g_wheel
    mjwm_wheel u_wheel (
      .speed (speed[w]),
      .gain  (gain),
      .en    (active),
      .dir_q (dir_q[w]),
      .duty  (res.duty[w]),
      .dir_d (res.dir[w])
    );
  end

endmodule
`default_nettype wire

### hw/rtl/mecanum_joystick_wheel_mixer_unit.sv
// Top level of the mecanum joystick wheel mixer.
`timescale 1ns / 1ps
`default_nettype none
// Takes one joystick sample per request (in_tuser = kind, 0 translate, 1 rotate)
// and returns one set of four wheel commands: an 8-bit PWM duty and a direction
// bit per wheel, in the order left front, left rear, right front, right rear.
// Axes are centered around 127 (y inverted), a squared-radius dead zone zeroes
// all duties, and the mixed speeds are scaled by an unsigned Q0.16 gain and
// truncated toward zero. A direction bit holds its value whenever its duty is
// zero. An accepted sample waits in the input register, then the squares,
// compare and four 9x16 multipliers run in a single pass into the result
// register, which raises out_tvalid. A new sample is accepted every cycle
// while out_tready is high; the result register keeps a finished result while
// the input register takes the next sample. Registers (APB, byte address): 0x0
// dead-zone radius squared, 0x4 translate gain, 0x8 rotate gain; write only
// while the block is idle.
`include "mecanum_joystick_wheel_mixer_unit_defines.svh"
module mecanum_joystick_wheel_mixer_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Input requests
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [2*mjwm_pkg::STICK_W-1:0]       in_tdata,  // stick_x, stick_y
  input  wire logic                                 in_tuser,  // kind
  // Result requests
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // left_front_duty, left_rear_duty, right_front_duty, right_rear_duty,
  // left_front_dir, left_rear_dir, right_front_dir, right_rear_dir, zero pad
  output logic [mjwm_pkg::OUT_DATA_W-1:0]           out_tdata,
  // Configuration
  input  wire logic                                 cfg_psel,
  input  wire logic                                 cfg_penable,
  input  wire logic                                 cfg_pwrite,
  input  wire logic [mjwm_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  wire logic [mjwm_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic      [mjwm_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                      cfg_pready
);
  import mjwm_pkg::*;

  localparam int PAD_W = OUT_DATA_W - WHEEL_COUNT * DUTY_W - WHEEL_COUNT;

  cfg_t     cfg;
  mix_res_t mix;

  // Input register: sample waiting for the mixing pass
  logic                   s1_valid_r, s1_valid_nxt;
  logic                   s1_kind_r;
  logic [STICK_W-1:0]     s1_x_r, s1_y_r;

  // Result register and wheel direction state
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r;
  logic [WHEEL_COUNT-1:0] dir_r, dir_nxt;

  logic in_acc;
  logic out_free;
  logic adv;

  mjwm_cfg_regs u_cfg_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  mjwm_mixer u_mixer (
    .kind    (s1_kind_r),
    .stick_x (s1_x_r),
    .stick_y (s1_y_r),
    .cfg     (cfg),
    .dir_q   (dir_r),
    .res     (mix)
  );

  // Advance the sample into the result register whenever that register is
  // empty or being drained this cycle
  assign out_free  = ~out_valid_r | out_tready;
  assign adv       = s1_valid_r & out_free;
  assign in_tready = ~s1_valid_r | adv;
  assign in_acc    = in_tvalid & in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    dir_nxt       = dir_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      dir_nxt       = mix.dir;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      dir_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      dir_r       <= dir_nxt;
    end
  end

  // Payload registers: load on accept or advance, hold otherwise
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r <= in_tuser;
      s1_x_r    <= in_tdata[STICK_W-1:0];
      s1_y_r    <= in_tdata[2*STICK_W-1:STICK_W];
    end
    if (adv) begin
      out_data_r <= {PAD_W'(0), mix.dir, mix.duty};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Direction state moves only when a sample passes the mixing pass
  `MJWM_ASSERT_NEXT(a_dir_only_on_adv, clk, rst_n, !adv, $stable(dir_r))
  // A wheel with zero duty keeps its direction bit
  `MJWM_ASSERT_NEXT(a_lf_zero_holds, clk, rst_n, adv && (mix.duty[WHEEL_LF] == '0),
                    dir_r[WHEEL_LF] == $past(dir_r[WHEEL_LF]))
  // A blocked sample stays in the input register
  `MJWM_ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_valid_r && !adv, s1_valid_r)
  // A pending result always shows the current direction state
  `MJWM_ASSERT_IMPLY(a_out_dir_match, clk, rst_n, out_valid_r,
                     out_data_r[WHEEL_COUNT*DUTY_W +: WHEEL_COUNT] == dir_r)

endmodule
`default_nettype wire
